/* src/modular_inverse_ext_euclid_unit_defines.svh */
// Assertion macros for the modular inverse unit.
// Included by the top level; no other dependencies.
`ifndef MODULAR_INVERSE_EXT_EUCLID_UNIT_DEFINES_SVH
`define MODULAR_INVERSE_EXT_EUCLID_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define MODINV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define MODINV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/modinv_pkg.sv */
// Shared types, constants and controller interface for the modular inverse unit.
// No dependencies.
package modinv_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [WIDTH-1:0] MODULUS_RESET = WIDTH'(1000000007);

    typedef logic [WIDTH-1:0] word_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_UPD,
        ST_RED,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic mul;
        logic upd;
        logic red;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic r1_zero;
    } dp_status_t;

endpackage

/* src/modinv_ifs.sv */
// Valid/ready channel interfaces for the modular inverse unit.
// Depends on modinv_pkg.
interface modinv_in_if
    import modinv_pkg::*;
    ();
    logic  valid;
    logic  ready;
    word_t value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface modinv_out_if
    import modinv_pkg::*;
    ();
    logic  valid;
    logic  ready;
    word_t inverse;

    modport source (output valid, output inverse, input ready);
    modport sink (input valid, input inverse, output ready);
endinterface

/* src/modinv_dp.sv */
// Datapath: remainder/coefficient registers, bit-serial divider, multiplier, reduction.
// Depends on modinv_pkg; driven by modinv_ctrl.
module modinv_dp
    import modinv_pkg::*;
(
    input  logic       clk,
    input  word_t      value,
    input  word_t      modulus,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output word_t      inverse
);

    word_t r0_reg, r0_next;
    word_t r1_reg, r1_next;
    word_t cu_reg, cu_next;
    word_t cv_reg, cv_next;
    logic  uneg_reg, uneg_next;
    word_t rem_reg, rem_next;
    word_t quo_reg, quo_next;
    word_t prod_reg, prod_next;
    word_t inverse_reg, inverse_next;

    logic [WIDTH:0]   shifted;
    word_t            trial;
    logic             ge;
    word_t            mul_lo;

    // trial is only taken when shifted >= r1, so the low bits hold the whole difference
    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign trial   = shifted[WIDTH-1:0] - r1_reg;
    assign ge      = shifted >= {1'b0, r1_reg};
    // q * cv never exceeds the modulus, so the low word is the full product
    assign mul_lo  = quo_reg * cv_reg;

    always_comb
    begin
        r0_next      = r0_reg;
        r1_next      = r1_reg;
        cu_next      = cu_reg;
        cv_next      = cv_reg;
        uneg_next    = uneg_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        prod_next    = prod_reg;
        inverse_next = inverse_reg;
        if (cmd.load)
        begin
            r0_next   = value;
            r1_next   = modulus;
            cu_next   = word_t'(1);
            cv_next   = '0;
            uneg_next = 1'b0;
        end
        if (cmd.div_init)
        begin
            rem_next = '0;
            quo_next = r0_reg;
        end
        if (cmd.div_step)
        begin
            rem_next = ge ? trial : shifted[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], ge};
        end
        if (cmd.mul)
        begin
            prod_next = mul_lo;
        end
        if (cmd.upd)
        begin
            r0_next   = r1_reg;
            r1_next   = rem_reg;
            cu_next   = cv_reg;
            cv_next   = cu_reg + prod_reg;
            uneg_next = !uneg_reg;
        end
        if (cmd.red)
        begin
            // cu never exceeds the modulus, so one conditional subtract reduces it
            cu_next = (cu_reg >= modulus) ? cu_reg - modulus : cu_reg;
        end
        if (cmd.out_load)
        begin
            inverse_next = (uneg_reg && cu_reg != '0) ? modulus - cu_reg : cu_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg      <= r0_next;
        r1_reg      <= r1_next;
        cu_reg      <= cu_next;
        cv_reg      <= cv_next;
        uneg_reg    <= uneg_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        prod_reg    <= prod_next;
        inverse_reg <= inverse_next;
    end

    assign status.r1_zero = (r1_reg == '0);
    assign inverse        = inverse_reg;

endmodule

/* src/modinv_ctrl.sv */
// Controller FSM: sequences Euclid rounds and owns the handshakes.
// Depends on modinv_pkg; drives modinv_dp.
module modinv_ctrl
    import modinv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    cnt_t   cnt_reg, cnt_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.r1_zero)
                begin
                    state_next = ST_RED;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + cnt_t'(1);
                if (cnt_reg == cnt_t'(WIDTH - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = ST_CHECK;
            end
            ST_RED:
            begin
                cmd.red    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

/* src/modular_inverse_ext_euclid_unit.sv */
// Channel   Dir  Payload            Handshake
// in_ch     in   value   [31:0]     valid/ready
// out_ch    out  inverse [31:0]     valid/ready
// cfg       in   cfg_data[31:0]     cfg_we, no read-back
//
// One transaction is a series of rounds; each round runs the
// bit-serial restoring divider plus check, multiply and update steps.
// The worst case is about 46 rounds at 32 bits.
// Reset is asynchronous, active low; modulus resets to 1000000007.
// The result register lets a new transaction start while a result waits;
// a finished result stalls in the done step until the output register frees.
// Depends on modinv_pkg, modinv_ifs, modinv_ctrl, modinv_dp and the defines header.
`include "modular_inverse_ext_euclid_unit_defines.svh"

module modular_inverse_ext_euclid_unit
    import modinv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_we,
    input  word_t cfg_data,
    modinv_in_if.sink    in_ch,
    modinv_out_if.source out_ch
);

    word_t      modulus_reg;
    dp_cmd_t    cmd;
    dp_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            modulus_reg <= cfg_data;
        end
    end

    modinv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    modinv_dp u_dp (
        .clk     (clk),
        .value   (in_ch.value),
        .modulus (modulus_reg),
        .cmd     (cmd),
        .status  (status),
        .inverse (out_ch.inverse)
    );

    `MODINV_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "input accepted while a transaction is in progress")
    `MODINV_ASSERT_SAME(a_result_reduced, clk, rst_n, out_ch.valid && modulus_reg != '0, out_ch.inverse < modulus_reg, "result not reduced below modulus")

endmodule

/* tb/sv/tb_modular_inverse_ext_euclid_unit.sv */
// Self-checking testbench for modular_inverse_ext_euclid_unit: drives values and
// modulus settings, predicts each inverse by extended Euclid and checks every result.
// Depends on modinv_pkg, modinv_ifs and the unit's RTL.
`timescale 1ns / 100ps

module tb_modular_inverse_ext_euclid_unit;
    import modinv_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_CYCLES = 64;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  cfg_we;
    word_t cfg_data;

    modinv_in_if  in_ch ();
    modinv_out_if out_ch ();

    modular_inverse_ext_euclid_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    word_t inverse_q[$];
    word_t modulus_cfg;
    bit    idle_on;
    int    hold_left;
    int    error_count;
    int    cycle_count;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic word_t expected_inverse(input word_t val, input word_t modulus);
        logic [63:0] rem_a, rem_b, rem_n;
        logic [63:0] coef_a, coef_b, coef_n;
        logic [63:0] quot, reduced;
        logic        a_neg;
        if (modulus == 0)
            return word_t'(1);
        rem_a  = 64'(val);
        rem_b  = 64'(modulus);
        coef_a = 64'd1;
        coef_b = 64'd0;
        a_neg  = 1'b0;
        while (rem_b != 0)
        begin
            quot   = rem_a / rem_b;
            rem_n  = rem_a - quot * rem_b;
            coef_n = coef_a + quot * coef_b;
            rem_a  = rem_b;
            rem_b  = rem_n;
            coef_a = coef_b;
            coef_b = coef_n;
            a_neg  = !a_neg;
        end
        reduced = coef_a % 64'(modulus);
        if (a_neg && reduced != 0)
            reduced = 64'(modulus) - reduced;
        return word_t'(reduced);
    endfunction

    task automatic send_value(input word_t val);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= val;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        inverse_q.push_back(expected_inverse(val, modulus_cfg));
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (inverse_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_modulus(input word_t modulus);
        @(negedge clk);
        cfg_we      <= 1'b1;
        cfg_data    <= modulus;
        modulus_cfg = modulus;
        @(negedge clk);
        cfg_we      <= 1'b0;
    endtask

    function automatic word_t pick_modulus();
        case ($urandom_range(0, 5))
            0: return word_t'($urandom_range(1, 1000));
            1: return word_t'(1) << $urandom_range(0, 31);
            2: return MODULUS_RESET;
            3: return 32'hFFFF_FFFF - word_t'($urandom_range(0, 8));
            default:
            begin
                word_t m;
                m = $urandom;
                return (m == 0) ? word_t'(1) : m;
            end
        endcase
    endfunction

    function automatic word_t pick_value(input word_t modulus);
        word_t near;
        near = word_t'($urandom_range(0, 4));
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, modulus - 1);
            2: return word_t'($urandom_range(0, 16));
            3: return (modulus > near) ? modulus - 1 - near : modulus + near;
            4: return word_t'($urandom_range(1, 6)) * (modulus / word_t'($urandom_range(1, 4)));
            default: return $urandom_range(0, modulus - 1);
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        word_t exp_inv;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (inverse_q.size() == 0)
            begin
                $error("inverse: expected none, got %0d", out_ch.inverse);
                error_count++;
            end
            else
            begin
                exp_inv = inverse_q.pop_front();
                if (out_ch.inverse !== exp_inv)
                begin
                    $error("inverse: expected %0d, got %0d", exp_inv, out_ch.inverse);
                    error_count++;
                end
            end
        end
    end

    // receiver: random stalls plus long hold-off on request
    initial
    begin
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 3) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("modular_inverse_ext_euclid_unit: mismatch");
            $finish;
        end
    end

    task automatic test_reset_modulus();
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd2);
        send_value(32'd1000000006);
        send_value(32'd1000000007);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        wait_drain();
    endtask

    task automatic test_extreme_moduli();
        write_modulus(32'hFFFF_FFFF);
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFE);
        send_value(32'hFFFF_FFFF);
        send_value(32'd3);
        send_value(32'hAAAA_AAAA);
        wait_drain();
        write_modulus(32'd1);
        send_value(32'd0);
        send_value(32'd5);
        send_value(32'hFFFF_FFFF);
        wait_drain();
        write_modulus(32'd2);
        send_value(32'd1);
        send_value(32'd3);
        wait_drain();
    endtask

    // consecutive Fibonacci numbers give the longest division chain
    task automatic test_longest_chain();
        write_modulus(32'd2971215073);
        send_value(32'd1836311903);
        send_value(32'd1134903170);
        wait_drain();
    endtask

    task automatic test_not_coprime();
        write_modulus(32'd360);
        send_value(32'd12);
        send_value(32'd7);
        send_value(32'd180);
        send_value(32'd359);
        send_value(32'd720);
        wait_drain();
    endtask

    task automatic test_random_moduli();
        for (int phase = 0; phase < 6; phase++)
        begin
            write_modulus(pick_modulus());
            for (int i = 0; i < 55; i++)
                send_value(pick_value(modulus_cfg));
            wait_drain();
        end
    endtask

    task automatic test_backpressure();
        write_modulus(MODULUS_RESET);
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 6; i++)
            send_value($urandom);
        wait_drain();
    endtask

    task automatic test_streaming();
        idle_on = 1'b0;
        write_modulus(pick_modulus());
        for (int i = 0; i < 40; i++)
            send_value(pick_value(modulus_cfg));
        wait_drain();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        idle_on     = 1'b1;
        hold_left   = 0;
        error_count = 0;
        cycle_count = 0;
        modulus_cfg = MODULUS_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_modulus();
        test_extreme_moduli();
        test_longest_chain();
        test_not_coprime();
        test_random_moduli();
        test_backpressure();
        test_streaming();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && inverse_q.size() == 0)
            $display("modular_inverse_ext_euclid_unit: match");
        else
            $display("modular_inverse_ext_euclid_unit: mismatch");
        $finish;
    end

endmodule

/* modular_inverse_ext_euclid_unit.f */
+incdir+src
src/modinv_pkg.sv
src/modinv_ifs.sv
src/modinv_dp.sv
src/modinv_ctrl.sv
src/modular_inverse_ext_euclid_unit.sv
tb/sv/tb_modular_inverse_ext_euclid_unit.sv
